>>> rtl/stsf_pkg.sv
// ----------------------------------------------------------------------------
// stsf_pkg: shared types and constants for the subarray target sum finder
// Field widths, result status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package stsf_pkg;

    localparam int MAX_LEN_DEF = 1024;

    localparam int ELEM_W   = 31;
    localparam int TARGET_W = 48;
    localparam int SUM_W    = 49;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TOO_LONG  = 2'd2;

    typedef struct packed {
        logic                load;
        logic                push;
        logic                pop;
        logic                set_res;
        logic [STATUS_W-1:0] res_code;
        logic                emit;
        logic                clear;
    } t_ctrl_cmd;

    typedef struct packed {
        logic answered;
        logic full;
        logic need_pop;
        logic found;
        logic last;
        logic out_busy;
    } t_dp_stat;

endpackage

>>> rtl/stsf_ctrl.sv
// ----------------------------------------------------------------------------
// stsf_ctrl: sequencing controller
// Steps each element through push, window shrink, match check and result.
// ----------------------------------------------------------------------------
module stsf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_is_last,
    input  logic                 i_ready,
    input  stsf_pkg::t_dp_stat   i_stat,
    output logic                 o_ready,
    output stsf_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SUB   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_code = stsf_pkg::STAT_FOUND;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.answered) begin
                        o_cmd.clear = i_is_last;
                    end else if (i_stat.full) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = stsf_pkg::STAT_TOO_LONG;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.need_pop) begin
                    n_state = S_SUB;
                end else if (i_stat.found) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = stsf_pkg::STAT_FOUND;
                    n_state        = S_EMIT;
                end else if (i_stat.last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = stsf_pkg::STAT_NOT_FOUND;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SUB: begin
                o_cmd.pop = 1'b1;
                n_state   = S_CHECK;
            end
            S_EMIT: begin
                if (!i_stat.out_busy || i_ready) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.clear = i_stat.last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/stsf_datapath.sv
// ----------------------------------------------------------------------------
// stsf_datapath: window store, running sum and result registers
// Holds the element FIFO memory, window pointers, target and output stage.
// ----------------------------------------------------------------------------
module stsf_datapath #(
    parameter int MAX_LEN = stsf_pkg::MAX_LEN_DEF,
    parameter int IDX_W   = $clog2(MAX_LEN + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [stsf_pkg::TARGET_W-1:0]   i_cfg_wdata,
    input  logic [stsf_pkg::ELEM_W-1:0]     i_element_value,
    input  logic                            i_is_last,
    input  logic                            i_ready,
    input  stsf_pkg::t_ctrl_cmd             i_cmd,
    output stsf_pkg::t_dp_stat              o_stat,
    output logic                            o_valid,
    output logic [stsf_pkg::STATUS_W-1:0]   o_status,
    output logic [IDX_W-1:0]                o_start_index,
    output logic [IDX_W-1:0]                o_end_index
);

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PAD_W  = stsf_pkg::SUM_W - stsf_pkg::ELEM_W;

    logic [stsf_pkg::ELEM_W-1:0]   r_mem [MAX_LEN];
    logic [stsf_pkg::ELEM_W-1:0]   r_rd_data;
    logic [stsf_pkg::ELEM_W-1:0]   r_elem;
    logic                          r_last;
    logic [stsf_pkg::TARGET_W-1:0] r_target;
    logic [stsf_pkg::SUM_W-1:0]    r_sum;
    logic [IDX_W-1:0]              r_start;
    logic [IDX_W-1:0]              r_seen;
    logic                          r_answered;

    logic [stsf_pkg::STATUS_W-1:0] r_res_status;
    logic [IDX_W-1:0]              r_res_start;
    logic [IDX_W-1:0]              r_res_end;

    logic                          r_out_valid;
    logic [stsf_pkg::STATUS_W-1:0] r_out_status;
    logic [IDX_W-1:0]              r_out_start;
    logic [IDX_W-1:0]              r_out_end;

    logic [stsf_pkg::SUM_W-1:0]    w_target_ext;
    logic                          w_window_live;
    logic                          w_target_zero;

    assign w_target_ext  = {1'b0, r_target};
    assign w_window_live = (r_start < r_seen);
    assign w_target_zero = (r_target == '0);

    always_comb begin
        o_stat.answered = r_answered;
        o_stat.full     = (r_seen == IDX_W'(MAX_LEN));
        o_stat.need_pop = (r_sum > w_target_ext) && w_window_live;
        o_stat.found    = w_target_zero ? (r_elem == '0)
                                        : (w_window_live && (r_sum == w_target_ext));
        o_stat.last     = r_last;
        o_stat.out_busy = r_out_valid;
    end

    // window store
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_seen[ADDR_W-1:0]] <= i_element_value;
        end
        r_rd_data <= r_mem[r_start[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_elem <= i_element_value;
            r_last <= i_is_last;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_code;
            if (i_cmd.res_code != stsf_pkg::STAT_FOUND) begin
                r_res_start <= '0;
                r_res_end   <= '0;
            end else if (w_target_zero) begin
                r_res_start <= r_seen;
                r_res_end   <= r_seen;
            end else begin
                r_res_start <= r_start + IDX_W'(1);
                r_res_end   <= r_seen;
            end
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_start  <= r_res_start;
            r_out_end    <= r_res_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_sum       <= '0;
            r_start     <= '0;
            r_seen      <= '0;
            r_answered  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_sum      <= '0;
                r_start    <= '0;
                r_seen     <= '0;
                r_answered <= 1'b0;
            end else begin
                if (i_cmd.push) begin
                    r_sum  <= r_sum + {{PAD_W{1'b0}}, i_element_value};
                    r_seen <= r_seen + IDX_W'(1);
                end
                if (i_cmd.pop) begin
                    r_sum   <= r_sum - {{PAD_W{1'b0}}, r_rd_data};
                    r_start <= r_start + IDX_W'(1);
                end
                if (i_cmd.set_res && (i_cmd.res_code != stsf_pkg::STAT_NOT_FOUND)) begin
                    r_answered <= 1'b1;
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_start_index = r_out_start;
    assign o_end_index   = r_out_end;

endmodule

>>> rtl/subarray_target_sum_finder.sv
// A pushed element goes to CHECK, then through SUB and back to CHECK per element dropped
//   from the window front; each drop is one memory read and one 49-bit subtract. A result
//   from CHECK goes to EMIT, which waits on the output stage; input is taken only in IDLE.
// Elements after a result are ignored; a too-long element goes straight to EMIT.
// Reset (synchronous, active low) clears the target, window pointers, sum and output valid;
//   the window store is not cleared.
// ----------------------------------------------------------------------------
// subarray_target_sum_finder: streaming contiguous subarray sum search
// Sliding window over each array; reports the first window matching the target.
// ----------------------------------------------------------------------------
module subarray_target_sum_finder #(
    parameter int MAX_LEN = stsf_pkg::MAX_LEN_DEF,
    parameter int IDX_W   = $clog2(MAX_LEN + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [stsf_pkg::TARGET_W-1:0]   i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [stsf_pkg::ELEM_W-1:0]     i_element_value,
    input  logic                            i_is_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [stsf_pkg::STATUS_W-1:0]   o_status,
    output logic [IDX_W-1:0]                o_start_index,
    output logic [IDX_W-1:0]                o_end_index
);

    stsf_pkg::t_ctrl_cmd w_cmd;
    stsf_pkg::t_dp_stat  w_stat;

    stsf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_is_last (i_is_last),
        .i_ready   (i_ready),
        .i_stat    (w_stat),
        .o_ready   (o_ready),
        .o_cmd     (w_cmd)
    );

    stsf_datapath #(
        .MAX_LEN (MAX_LEN),
        .IDX_W   (IDX_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_element_value (i_element_value),
        .i_is_last       (i_is_last),
        .i_ready         (i_ready),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_start_index   (o_start_index),
        .o_end_index     (o_end_index)
    );

endmodule

>>> rtl/stsf_checker.sv
// ----------------------------------------------------------------------------
// stsf_checker: port-level checks for the subarray target sum finder
// Watches the result channel hold behavior and the reported index ranges.
// ----------------------------------------------------------------------------
module stsf_checker #(
    parameter int MAX_LEN = stsf_pkg::MAX_LEN_DEF,
    parameter int IDX_W   = $clog2(MAX_LEN + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [stsf_pkg::STATUS_W-1:0] o_status,
    input logic [IDX_W-1:0]              o_start_index,
    input logic [IDX_W-1:0]              o_end_index
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready
        |=> $stable(o_status) && $stable(o_start_index) && $stable(o_end_index))
        else $error("result changed before transfer");

    a_miss_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != stsf_pkg::STAT_FOUND)
        |-> (o_start_index == '0) && (o_end_index == '0))
        else $error("nonzero index on a miss result");

    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == stsf_pkg::STAT_FOUND)
        |-> (o_start_index != '0) && (o_start_index <= o_end_index)
            && (o_end_index <= IDX_W'(MAX_LEN)))
        else $error("match indices out of range");

endmodule

bind subarray_target_sum_finder stsf_checker #(
    .MAX_LEN (MAX_LEN),
    .IDX_W   (IDX_W)
) u_stsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_start_index (o_start_index),
    .o_end_index   (o_end_index)
);
